>>> rtl/core/ricx_pkg.sv
// Shared types and constants for the RIFF ICCP chunk extractor.
// Holds the parse phase type, the result item struct and the signature byte helper.
// No dependencies.
package ricx_pkg;

	typedef enum logic [2:0] {
		PH_HEADER     = 3'd0,
		PH_CHUNK_HEAD = 3'd1,
		PH_SKIP       = 3'd2,
		PH_PAYLOAD    = 3'd3,
		PH_DONE       = 3'd4
	} phase_t;

	localparam int unsigned RICX_QUEUE_DEPTH = 2;

	localparam logic KIND_PROFILE = 1'b0;
	localparam logic KIND_NONE    = 1'b1;

	localparam logic [31:0] TAG_ICCP = 32'h4943_4350;
	localparam logic [31:0] SIG_RIFF = 32'h5249_4646;
	localparam logic [31:0] SIG_WEBP = 32'h5745_4250;

	localparam logic [31:0] HDR_BYTES     = 32'd12;
	localparam logic [3:0]  CHUNK_HDR_LEN = 4'd8;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t item;
	} res_push_t;

	// Byte idx of a four-character code, byte 0 being the first character.
	function automatic logic [7:0] sig_byte(input logic [31:0] sig, input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = sig[31:24];
			2'd1:    r = sig[23:16];
			2'd2:    r = sig[15:8];
			default: r = sig[7:0];
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/ricx_ifs.sv
// Channel interfaces of the RIFF ICCP chunk extractor: byte input, result
// output and the stream length write channel. Each has source and sink modports.
// No dependencies.
interface ricx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface ricx_res_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] profile_byte;
	logic       final_item;
	modport source (output valid, output result_kind, output profile_byte, output final_item,
		input ready);
	modport sink (input valid, input result_kind, input profile_byte, input final_item,
		output ready);
endinterface

interface ricx_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] stream_length;
	modport source (output valid, output stream_length, input ready);
	modport sink (input valid, input stream_length, output ready);
endinterface

>>> rtl/core/ricx_front.sv
// Front part of the extractor: takes file bytes, walks the RIFF/WebP layout and
// pushes result items into the queue. Holds the stream length register.
// Depends on ricx_pkg and ricx_ifs.
module ricx_front
	import ricx_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	ricx_byte_if.sink      stream,
	ricx_cfg_if.sink       cfg,
	input  logic           q_full,
	output res_push_t      push
);

	logic [31:0] len_q;
	logic [32:0] nxt_q;       // byte position plus one
	phase_t      phase_q, phase_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] size_q, size_d;
	logic [31:0] left_q, left_d;
	logic        sig_good_q, sig_good_d;
	logic [32:0] nxt_d;

	logic        acc;
	logic [7:0]  b;
	logic [32:0] len33;
	logic        at_end;
	logic        short_file;
	logic        in_riff, in_webp, hdr_last;
	logic [1:0]  pos_lo;
	logic [7:0]  sig_exp;
	logic        sig_good_new;
	logic [3:0]  left_ch, left_ch_dec;
	logic        head_done;
	logic [31:0] tag_new, size_new;
	logic [33:0] size_end;
	logic        too_long;
	logic        is_iccp;
	logic [32:0] skip;
	logic [31:0] skip_cap;
	logic [31:0] left_dec;
	logic        left_zero;
	logic        sw_none, sw_prof, prof_last, end_none;

	assign stream.ready = ~q_full;
	assign cfg.ready    = 1'b1;
	assign acc          = stream.valid & ~q_full;
	assign b            = stream.data_byte;

	assign len33      = {1'b0, len_q};
	assign at_end     = nxt_q >= len33;
	assign short_file = len_q < HDR_BYTES;

	assign in_riff  = nxt_q < 33'd5;
	assign in_webp  = (nxt_q >= 33'd9) && (nxt_q <= 33'd12);
	assign hdr_last = nxt_q >= 33'd12;
	assign pos_lo   = nxt_q[1:0] - 2'd1;
	assign sig_exp  = in_riff ? sig_byte(SIG_RIFF, pos_lo) : sig_byte(SIG_WEBP, pos_lo);
	assign sig_good_new = sig_good_q & ~((in_riff | in_webp) && (b != sig_exp));

	// A header count outside one to eight restarts the eight-byte header.
	assign left_ch     = ((left_q == 32'd0) || (left_q > 32'd8)) ? CHUNK_HDR_LEN : left_q[3:0];
	assign left_ch_dec = left_ch - 4'd1;
	assign head_done   = left_ch_dec == 4'd0;
	assign tag_new     = (left_ch > 4'd4) ? {tag_q[23:0], b} : tag_q;
	assign size_new    = (left_ch > 4'd4) ? size_q : {b, size_q[31:8]};

	// Chunk longer than what follows its header: size + next > length.
	assign size_end = {2'b00, size_new} + {1'b0, nxt_q};
	assign too_long = (size_new != 32'd0) && (size_end > {2'b00, len_q});
	assign is_iccp  = tag_new == TAG_ICCP;
	assign skip     = {1'b0, size_new} + {32'd0, size_new[0]};
	assign skip_cap = skip[32] ? 32'hFFFF_FFFF : skip[31:0];

	assign left_dec  = (left_q == 32'd0) ? 32'd0 : left_q - 32'd1;
	assign left_zero = left_dec == 32'd0;

	assign sw_none = ((phase_q == PH_HEADER) && (short_file || (hdr_last && !sig_good_new)))
		|| ((phase_q == PH_CHUNK_HEAD) && head_done
			&& (too_long || (is_iccp && (size_new == 32'd0))));
	assign sw_prof   = phase_q == PH_PAYLOAD;
	assign prof_last = left_zero | at_end;
	assign end_none  = at_end && !sw_prof && !sw_none && (phase_q != PH_DONE);

	// Next state
	always_comb begin
		phase_d    = phase_q;
		tag_d      = tag_q;
		size_d     = size_q;
		left_d     = left_q;
		sig_good_d = sig_good_q;
		case (phase_q)
			PH_HEADER: begin
				if (!short_file) begin
					sig_good_d = sig_good_new;
					if (hdr_last && sig_good_new) begin
						phase_d = PH_CHUNK_HEAD;
						left_d  = 32'(CHUNK_HDR_LEN);
						tag_d   = '0;
						size_d  = '0;
					end
				end
			end
			PH_CHUNK_HEAD: begin
				tag_d  = tag_new;
				size_d = size_new;
				left_d = {28'd0, left_ch_dec};
				if (head_done && !too_long) begin
					if (is_iccp) begin
						if (size_new != 32'd0) begin
							phase_d = PH_PAYLOAD;
							left_d  = size_new;
						end
					end else if (size_new == 32'd0) begin
						left_d = 32'(CHUNK_HDR_LEN);
						tag_d  = '0;
						size_d = '0;
					end else begin
						phase_d = PH_SKIP;
						left_d  = skip_cap;
					end
				end
			end
			PH_SKIP: begin
				left_d = left_dec;
				if (left_zero) begin
					phase_d = PH_CHUNK_HEAD;
					left_d  = 32'(CHUNK_HDR_LEN);
					tag_d   = '0;
					size_d  = '0;
				end
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				if (prof_last)
					phase_d = PH_DONE;
			end
			default: begin
			end
		endcase
		if (sw_none)
			phase_d = PH_DONE;
		if (at_end) begin
			nxt_d      = 33'd1;
			phase_d    = PH_HEADER;
			tag_d      = '0;
			size_d     = '0;
			left_d     = '0;
			sig_good_d = 1'b1;
		end else begin
			nxt_d = nxt_q + 33'd1;
		end
	end

	// Outputs
	always_comb begin
		push.valid = acc & (sw_none | sw_prof | end_none);
		if (sw_prof) begin
			push.item.kind = KIND_PROFILE;
			push.item.data = b;
			push.item.last = prof_last;
		end else begin
			push.item.kind = KIND_NONE;
			push.item.data = 8'd0;
			push.item.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			nxt_q      <= 33'd1;
			phase_q    <= PH_HEADER;
			tag_q      <= '0;
			size_q     <= '0;
			left_q     <= '0;
			sig_good_q <= 1'b1;
		end else begin
			if (cfg.valid)
				len_q <= cfg.stream_length;
			if (acc) begin
				nxt_q      <= nxt_d;
				phase_q    <= phase_d;
				tag_q      <= tag_d;
				size_q     <= size_d;
				left_q     <= left_d;
				sig_good_q <= sig_good_d;
			end
		end
	end

endmodule

>>> rtl/core/ricx_queue.sv
// Short result queue between the parsing front and the output stage.
// A push and a pop may happen in the same cycle.
// Depends on ricx_pkg.
module ricx_queue
	import ricx_pkg::*;
#(
	parameter int unsigned Depth = RICX_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t push,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output res_t      head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	res_t            mem [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full    = cnt_q == CntW'(Depth);
	assign empty   = cnt_q == '0;
	assign do_push = push.valid & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CntW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

endmodule

>>> rtl/core/ricx_back.sv
// Output stage of the extractor: takes result items from the queue into an
// output register and holds them until the sink takes the transaction.
// Depends on ricx_pkg and ricx_ifs.
module ricx_back
	import ricx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  res_t       head,
	output logic       pop,
	ricx_res_if.source results
);

	logic valid_q;
	res_t item_q;

	assign pop = ~empty & (~valid_q | results.ready);

	assign results.valid        = valid_q;
	assign results.result_kind  = item_q.kind;
	assign results.profile_byte = item_q.data;
	assign results.final_item   = item_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			item_q <= head;
	end

endmodule

>>> rtl/core/riff_iccp_chunk_extractor.sv
// Streams a RIFF/WebP file one byte per transaction and passes out the payload of
// its first ICCP chunk if that chunk fits inside the file, or one no-profile item per file.
// Write stream_length before the first byte of each file. The block takes one byte
// every cycle. A result is written into the result queue when its byte is taken, then
// moves to the output register, which presents it until the result sink takes it.
// The input stalls only when the result queue (QueueDepth entries) is full because
// the result sink holds off. Depends on ricx_pkg, ricx_ifs, ricx_front, ricx_queue
// and ricx_back.
module riff_iccp_chunk_extractor
	import ricx_pkg::*;
#(
	parameter int unsigned QueueDepth = RICX_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	ricx_byte_if.sink  stream,
	ricx_cfg_if.sink   cfg,
	ricx_res_if.source results
);

	res_push_t push;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	res_t      q_head;

	ricx_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push)
	);

	ricx_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	ricx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.head    (q_head),
		.pop     (q_pop),
		.results (results)
	);

endmodule

>>> verif/riff_iccp_chunk_extractor_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for riff_iccp_chunk_extractor: streams whole RIFF/WebP files and
// noise through the byte channel and checks every result against a file walker or a directed row.
// Depends on ricx_pkg, the ricx channel interfaces and the extractor RTL.
module riff_iccp_chunk_extractor_tb;
	import ricx_pkg::*;

	localparam int unsigned RANDOM_BYTES = 600;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam longint unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RIFF_END = 4;
	localparam int unsigned WEBP_START = 8;
	localparam int unsigned TAG_BYTES = 4;

	typedef enum logic [1:0] {
		ROW_CFG,        // write stream_length
		ROW_BYTE,       // byte checked against the walker
		ROW_BYTE_QUIET, // byte that must give no result
		ROW_BYTE_NONE   // byte that must give the no-profile answer
	} row_op_t;

	typedef struct packed {
		row_op_t     op;
		logic [31:0] value;
	} row_t;

	localparam res_t NO_PROFILE = '{kind: KIND_NONE, data: 8'h00, last: 1'b1};

	localparam int DIR_ROWS = 38;
	localparam row_t DIRECTED [DIR_ROWS] = '{
		// Zero-length file: every byte is a file of its own.
		'{ROW_CFG, 32'd0}, '{ROW_BYTE_NONE, 32'h00}, '{ROW_BYTE_NONE, 32'hFF},
		// Short file answers on its first byte, then the rest is ignored.
		'{ROW_CFG, 32'd3}, '{ROW_BYTE_NONE, 32'h52}, '{ROW_BYTE_QUIET, 32'h49},
		'{ROW_BYTE_QUIET, 32'h46},
		// Bad signature in the last header byte.
		'{ROW_CFG, 32'd12},
		'{ROW_BYTE_QUIET, 32'h52}, '{ROW_BYTE_QUIET, 32'h49}, '{ROW_BYTE_QUIET, 32'h46},
		'{ROW_BYTE_QUIET, 32'h46}, '{ROW_BYTE_QUIET, 32'h00}, '{ROW_BYTE_QUIET, 32'h00},
		'{ROW_BYTE_QUIET, 32'h00}, '{ROW_BYTE_QUIET, 32'h00}, '{ROW_BYTE_QUIET, 32'h57},
		'{ROW_BYTE_QUIET, 32'h45}, '{ROW_BYTE_QUIET, 32'h42}, '{ROW_BYTE_NONE, 32'h58},
		// Largest length, then shrunk below the current position mid-file.
		'{ROW_CFG, 32'hFFFF_FFFF}, '{ROW_BYTE_QUIET, 32'h52},
		'{ROW_CFG, 32'd1}, '{ROW_BYTE_NONE, 32'h49},
		// Good header, file ends inside the first chunk header.
		'{ROW_CFG, 32'd13},
		'{ROW_BYTE, 32'h52}, '{ROW_BYTE, 32'h49}, '{ROW_BYTE, 32'h46}, '{ROW_BYTE, 32'h46},
		'{ROW_BYTE, 32'h10}, '{ROW_BYTE, 32'h20}, '{ROW_BYTE, 32'h40}, '{ROW_BYTE, 32'h80},
		'{ROW_BYTE, 32'h57}, '{ROW_BYTE, 32'h45}, '{ROW_BYTE, 32'h42}, '{ROW_BYTE, 32'h50},
		'{ROW_BYTE_NONE, 32'h49}
	};

	logic clk = 1'b0;
	logic arst_n;

	ricx_byte_if byte_ch();
	ricx_cfg_if  cfg_ch();
	ricx_res_if  res_ch();

	riff_iccp_chunk_extractor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.cfg    (cfg_ch),
		.results(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// File walker state.
	logic [31:0] walk_len;
	logic [31:0] walk_pos;
	logic [31:0] walk_tag;
	logic [31:0] walk_size;
	logic [31:0] walk_left;
	phase_t      walk_phase;
	logic        walk_sig_ok;
	logic        walk_answered;

	res_t           pending[$];
	logic [7:0]     file_bytes[$];
	longint unsigned cycle_count = 0;
	int unsigned    errors = 0;
	int unsigned    results_seen = 0;
	int unsigned    none_seen = 0;
	int unsigned    bytes_sent = 0;
	int unsigned    files_sent = 0;
	int unsigned    length_writes = 0;
	int unsigned    rewrites = 0;
	int unsigned    burst_left = 0;
	logic [15:0]    stall_mask = 16'hFFFF;
	logic [7:0]     stall_tick = 8'd0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want_v);
		errors++;
		if (errors <= 40)
			$display("ERROR cycle %0d result %0d: %s is %0h, should be %0h",
				cycle_count, results_seen, what, got, want_v);
	endtask

	function automatic void clear_walk();
		walk_pos = '0;
		walk_phase = PH_HEADER;
		walk_tag = '0;
		walk_size = '0;
		walk_left = '0;
		walk_sig_ok = 1'b1;
		walk_answered = 1'b0;
	endfunction

	function automatic res_t give_no_profile();
		walk_answered = 1'b1;
		walk_phase = PH_DONE;
		return NO_PROFILE;
	endfunction

	function automatic void open_chunk_head();
		walk_phase = PH_CHUNK_HEAD;
		walk_left = 32'(CHUNK_HDR_LEN);
		walk_tag = '0;
		walk_size = '0;
	endfunction

	// Advances the walker by one byte; returns 1 when the byte yields a result item.
	function automatic bit walk_byte(input logic [7:0] b, output res_t r);
		logic [32:0] nxt;
		logic [32:0] rem;
		logic [32:0] skip;
		logic [31:0] hl;
		bit          got;
		got = 1'b0;
		r = NO_PROFILE;
		nxt = {1'b0, walk_pos} + 33'd1;
		rem = ({1'b0, walk_len} > nxt) ? {1'b0, walk_len} - nxt : 33'd0;
		if (!walk_answered) begin
			case (walk_phase)
			PH_HEADER: begin
				if (walk_len < HDR_BYTES) begin
					r = give_no_profile();
					got = 1'b1;
				end else begin
					if (walk_pos < RIFF_END) begin
						if (b != SIG_RIFF[8 * (3 - walk_pos[1:0]) +: 8])
							walk_sig_ok = 1'b0;
					end else if (walk_pos >= WEBP_START && walk_pos < HDR_BYTES) begin
						if (b != SIG_WEBP[8 * (3 - walk_pos[1:0]) +: 8])
							walk_sig_ok = 1'b0;
					end
					if (walk_pos >= HDR_BYTES - 1) begin
						if (!walk_sig_ok) begin
							r = give_no_profile();
							got = 1'b1;
						end else begin
							open_chunk_head();
						end
					end
				end
			end
			PH_CHUNK_HEAD: begin
				hl = walk_left;
				if (hl == 0 || hl > CHUNK_HDR_LEN)
					hl = 32'(CHUNK_HDR_LEN);
				// Id bytes come first, most significant first; the length is little-endian.
				if (hl > TAG_BYTES)
					walk_tag = {walk_tag[23:0], b};
				else
					walk_size = {b, walk_size[31:8]};
				hl = hl - 32'd1;
				walk_left = hl;
				if (hl == 0) begin
					if ({1'b0, walk_size} > rem) begin
						r = give_no_profile();
						got = 1'b1;
					end else if (walk_tag == TAG_ICCP) begin
						if (walk_size == 0) begin
							r = give_no_profile();
							got = 1'b1;
						end else begin
							walk_phase = PH_PAYLOAD;
							walk_left = walk_size;
						end
					end else begin
						skip = {1'b0, walk_size} + {32'd0, walk_size[0]};
						if (skip == 0) begin
							open_chunk_head();
						end else begin
							walk_phase = PH_SKIP;
							walk_left = skip[32] ? 32'hFFFF_FFFF : skip[31:0];
						end
					end
				end
			end
			PH_SKIP: begin
				if (walk_left > 0)
					walk_left = walk_left - 32'd1;
				if (walk_left == 0)
					open_chunk_head();
			end
			PH_PAYLOAD: begin
				if (walk_left > 0)
					walk_left = walk_left - 32'd1;
				r.kind = KIND_PROFILE;
				r.data = b;
				r.last = (walk_left == 0) || (nxt >= {1'b0, walk_len});
				got = 1'b1;
				if (r.last) begin
					walk_answered = 1'b1;
					walk_phase = PH_DONE;
				end
			end
			default: ;
			endcase
		end
		if (nxt >= {1'b0, walk_len}) begin
			if (!walk_answered && !got) begin
				r = give_no_profile();
				got = 1'b1;
			end
			clear_walk();
		end else begin
			walk_pos = nxt[31:0];
		end
		return got;
	endfunction

	function automatic void push_be(input logic [31:0] w);
		for (int k = 3; k >= 0; k--)
			file_bytes.push_back(w[8 * k +: 8]);
	endfunction

	function automatic void push_le(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			file_bytes.push_back(w[8 * k +: 8]);
	endfunction

	function automatic void add_chunk(input logic [31:0] tag, input int unsigned size);
		push_be(tag);
		push_le(size);
		repeat (size + size % 2)
			file_bytes.push_back(8'($urandom));
	endfunction

	// Random chunk id that is never ICCP, often one character away from it.
	function automatic logic [31:0] stray_tag();
		logic [31:0] t;
		t = $urandom;
		if ($urandom_range(0, 2) == 0) begin
			t = TAG_ICCP;
			t[8 * $urandom_range(0, 3) +: 8] = 8'($urandom);
		end
		if (t == TAG_ICCP)
			t[0] = ~t[0];
		return t;
	endfunction

	task automatic build_file(output logic [31:0] flen);
		int unsigned pick;
		int unsigned iccp_size;
		int unsigned size_at;
		int unsigned sig_at;
		logic [32:0] wide;
		logic [31:0] declared;
		bit          with_iccp;
		file_bytes.delete();
		pick = $urandom_range(0, 99);
		if (pick >= 80) begin
			repeat ($urandom_range(1, 24))
				file_bytes.push_back(8'($urandom));
			flen = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'(file_bytes.size());
		end else begin
			push_be(SIG_RIFF);
			push_le($urandom);
			push_be(SIG_WEBP);
			if (pick < 15) begin
				sig_at = $urandom_range(0, 7);
				if (sig_at >= RIFF_END)
					sig_at += RIFF_END;
				file_bytes[sig_at] = file_bytes[sig_at] ^ (8'h01 << $urandom_range(0, 7));
			end
			repeat ($urandom_range(0, 3))
				add_chunk(stray_tag(), $urandom_range(0, 7));
			with_iccp = ($urandom_range(0, 9) != 0);
			iccp_size = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
			size_at = 32'(file_bytes.size()) + TAG_BYTES;
			if (with_iccp)
				add_chunk(TAG_ICCP, iccp_size);
			if ($urandom_range(0, 2) == 0)
				add_chunk(stray_tag(), $urandom_range(0, 5));
			flen = 32'(file_bytes.size());
			case ($urandom_range(0, 9))
			0: begin
				// Truncated file.
				flen = $urandom_range(1, flen - 1);
				while (file_bytes.size() > flen)
					file_bytes.delete(file_bytes.size() - 1);
			end
			1: begin
				// Declared profile length that may not fit the file.
				if (with_iccp) begin
					declared = $urandom_range(0, 1) ? $urandom : iccp_size + $urandom_range(1, 40);
					for (int k = 0; k < 4; k++)
						file_bytes[size_at + k] = declared[8 * k +: 8];
				end
			end
			2: begin
				// Length far past the bytes sent: the next file starts mid-walk.
				wide = {1'b0, flen} + {1'b0, 32'($urandom)};
				flen = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
			end
			default: ;
			endcase
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input row_op_t how);
		int unsigned gap;
		res_t        got;
		bit          has;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		@(posedge clk);
		while (byte_ch.ready !== 1'b1)
			@(posedge clk);
		has = walk_byte(b, got);
		bytes_sent++;
		case (how)
		ROW_BYTE_QUIET: ;
		ROW_BYTE_NONE: pending.push_back(NO_PROFILE);
		default: begin
			if (has)
				pending.push_back(got);
		end
		endcase
	endtask

	// Holds the sender until every pending result is out and the pipeline is empty.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [31:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.stream_length <= v;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		walk_len = v;
		length_writes++;
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Receiver stall pattern, reshuffled whenever the eight-bit stall tick wraps.
	always @(posedge clk) begin
		if (stall_tick == 0) begin
			case ($urandom_range(0, 3))
			0: stall_mask <= 16'hFFFF;
			1: stall_mask <= 16'($urandom);
			2: stall_mask <= 16'h0001 << $urandom_range(0, 15);
			default: stall_mask <= 16'($urandom) | 16'h8421;
			endcase
		end
		stall_tick <= stall_tick + 8'd1;
		res_ch.ready <= stall_mask[stall_tick[3:0]];
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			if (res_ch.result_kind === KIND_NONE)
				none_seen++;
			if (pending.size() == 0) begin
				report("result with nothing pending",
					32'({res_ch.result_kind, res_ch.profile_byte, res_ch.final_item}), 32'd0);
			end else begin
				want = pending.pop_front();
				if (res_ch.result_kind !== want.kind)
					report("result_kind", 32'(res_ch.result_kind), 32'(want.kind));
				if (res_ch.profile_byte !== want.data)
					report("profile_byte", 32'(res_ch.profile_byte), 32'(want.data));
				if (res_ch.final_item !== want.last)
					report("final_item", 32'(res_ch.final_item), 32'(want.last));
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d results pending", cycle_count, pending.size());
		$display("riff_iccp_chunk_extractor: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] flen;
		logic [31:0] new_len;
		int          rewrite_at;
		int unsigned byte_target;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.stream_length <= '0;
		arst_n <= 1'b0;
		walk_len = '0;
		clear_walk();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].op == ROW_CFG) begin
				settle();
				set_length(DIRECTED[i].value);
			end else begin
				send_byte(DIRECTED[i].value[7:0], DIRECTED[i].op);
			end
		end

		byte_target = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < byte_target) begin
			build_file(flen);
			settle();
			set_length(flen);
			files_sent++;
			rewrite_at = -1;
			if (file_bytes.size() > 2 && $urandom_range(0, 11) == 0)
				rewrite_at = $urandom_range(1, file_bytes.size() - 1);
			foreach (file_bytes[i]) begin
				if (i == rewrite_at) begin
					settle();
					if ($urandom_range(0, 2) == 0)
						new_len = $urandom_range(0, i);
					else
						new_len = $urandom_range(i, file_bytes.size() + 8);
					set_length(new_len);
					rewrites++;
				end
				send_byte(file_bytes[i], ROW_BYTE);
			end
		end

		byte_ch.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (pending.size() != 0)
			report("results still outstanding", 32'(pending.size()), 32'd0);

		$display("Streamed %0d bytes over %0d random files, %0d length writes (%0d mid-file)",
			bytes_sent, files_sent, length_writes, rewrites);
		$display("Checked %0d results: %0d profile bytes and %0d no-profile answers",
			results_seen, results_seen - none_seen, none_seen);
		if (errors == 0)
			$display("riff_iccp_chunk_extractor: match");
		else
			$display("riff_iccp_chunk_extractor: mismatch");
		$finish;
	end

endmodule
